### hdl/mah_pkg.sv
// Shared types and constants for the memory access histogram block.
// Holds the register map, result codes, queue payload structs and back-end states.
// No dependencies; compile first.
package mah_pkg;

  // Type byte handling
  localparam logic [7:0] TYPE_LIMIT  = 8'd64;
  localparam logic [7:0] KIND_MASK   = 8'h07;
  localparam int unsigned WIDTH_SHIFT = 3;

  // Class codes that pick a counter
  localparam logic [7:0] CLS_FIRST  = 8'd1;
  localparam logic [7:0] CLS_SECOND = 8'd2;
  localparam logic [7:0] CLS_THIRD  = 8'd4;

  // Configuration port
  localparam int unsigned CFG_ADDR_W = 4;

  typedef enum logic [1:0] {
    REG_WINDOW_START = 2'd0,
    REG_WINDOW_END   = 2'd1,
    REG_GROUP_SHIFT  = 2'd2,
    REG_WIDTH_MODE   = 2'd3
  } reg_idx_e;

  typedef enum logic {
    KIND_RECORD = 1'b0,
    KIND_QUERY  = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    ST_RECORDED    = 2'd0,
    ST_OUT_WINDOW  = 2'd1,
    ST_NO_CAPACITY = 2'd2,
    ST_QUERY_OK    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    WARN_NONE       = 2'd0,
    WARN_TYPE_RANGE = 2'd1,
    WARN_CLASS      = 2'd2
  } warn_e;

  typedef enum logic [1:0] {
    CNT_FIRST  = 2'd0,
    CNT_SECOND = 2'd1,
    CNT_THIRD  = 2'd2
  } which_e;

  typedef enum logic [2:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_READ,
    BK_UPDATE,
    BK_EMIT
  } back_state_e;

  // Configuration as seen by the front end, with precomputed bin bounds
  typedef struct packed {
    logic [31:0] window_start;
    logic [31:0] window_end;
    logic [4:0]  group_shift;
    logic        width_mode;
    logic [31:0] start_bin;
    logic [31:0] end_bin;
    logic        win_empty;
  } cfg_t;

  // Classified item handed from front to back
  typedef struct packed {
    logic [1:0] status;
    logic [1:0] warn;
    logic [1:0] which;
  } item_t;

  // One result item
  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  warn;
    logic [31:0] first_count;
    logic [31:0] second_count;
    logic [31:0] third_count;
    logic [33:0] total_count;
    logic [6:0]  bar_length;
  } res_t;

  // Back-end status seen by the top level
  typedef struct packed {
    logic clearing;
  } back_stat_t;

endpackage

### hdl/memory_access_histogram.sv
// Memory access histogram: top level with the configuration registers and the queues.
// Depends on mah_pkg, mah_queue, mah_front and mah_back.
//
// Counts a trace of memory accesses into address bins, one saturating counter per bin for
// each of three classes (read/write/fetch, or byte/half/word in width mode), and answers
// queries with a bin's three counts, their sum and a half-octave bar length. Items go in
// through push/full and results come out through empty/pop, one result per item, in order.
// After reset the block runs a clearing pass over all NUM_BINS entries of the counter memories;
// full stays high until it ends, while configuration writes are taken as usual.
// The front end registers an item and classifies it from that register, then hands it
// through a two-entry queue to the back end, which handles one item at a time: a record
// or a valid query goes through take from the queue, memory read, counter update or sum
// and result push; an item outside the window or beyond capacity skips read and update.
// The back end's counter read-modify-write sets the pace. Results wait in a two-entry queue,
// so the block keeps working while the consumer stalls. Configuration should be changed only
// while no item is in flight.
module memory_access_histogram #(
  parameter int NUM_BINS   = 1024,
  parameter int COUNT_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // item side
  input  logic        push,
  output logic        full,
  input  logic        kind_i,
  input  logic [31:0] access_address_i,
  input  logic [7:0]  access_type_i,
  // result side
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  status_o,
  output logic [1:0]  type_warning_o,
  output logic [31:0] first_count_o,
  output logic [31:0] second_count_o,
  output logic [31:0] third_count_o,
  output logic [33:0] total_count_o,
  output logic [6:0]  bar_length_o,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [mah_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import mah_pkg::*;

  localparam int BIN_W = $clog2(NUM_BINS);

  // Configuration registers
  logic [31:0] window_start_q, window_end_q;
  logic [4:0]  group_shift_q;
  logic        width_mode_q;
  logic [31:0] start_bin_q, end_bin_q;
  logic        win_empty_q;
  logic        cfg_wr;
  reg_idx_e    reg_idx;
  cfg_t        cfg;

  // Front/back plumbing
  logic             front_ready;
  logic             mid_push, mid_full, mid_pop, mid_empty;
  item_t            mid_item_w, mid_item_r;
  logic [BIN_W-1:0] mid_bin_w, mid_bin_r;
  logic [$bits(item_t)+BIN_W-1:0] mid_rd_data;
  logic             out_push, out_full;
  res_t             back_res, out_res;
  back_stat_t       back_stat;

  // --------------------------------------------------------------------------
  // Configuration port: writes land in the access phase, reads are a plain mux
  // --------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_start_q <= '0;
      window_end_q   <= '1;
      group_shift_q  <= 5'd2;
      width_mode_q   <= 1'b0;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_WINDOW_START: window_start_q <= pwdata;
        REG_WINDOW_END:   window_end_q   <= pwdata;
        REG_GROUP_SHIFT:  group_shift_q  <= pwdata[4:0];
        REG_WIDTH_MODE:   width_mode_q   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_WINDOW_START: prdata = window_start_q;
      REG_WINDOW_END:   prdata = window_end_q;
      REG_GROUP_SHIFT:  prdata = {27'd0, group_shift_q};
      REG_WIDTH_MODE:   prdata = {31'd0, width_mode_q};
      default:          prdata = '0;
    endcase
  end

  // Hold the window bounds in bin units so the front end only compares.
  // They update in the cycle after a write; an item taken after the write is classified from
  // the stage A register, by which time the bounds hold the fresh values.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_bin_q <= 32'h0000_0000;
      end_bin_q   <= 32'h3FFF_FFFF;
      win_empty_q <= 1'b0;
    end else begin
      start_bin_q <= window_start_q >> group_shift_q;
      end_bin_q   <= window_end_q >> group_shift_q;
      win_empty_q <= (window_start_q > window_end_q);
    end
  end

  always_comb begin
    cfg.window_start = window_start_q;
    cfg.window_end   = window_end_q;
    cfg.group_shift  = group_shift_q;
    cfg.width_mode   = width_mode_q;
    cfg.start_bin    = start_bin_q;
    cfg.end_bin      = end_bin_q;
    cfg.win_empty    = win_empty_q;
  end

  // --------------------------------------------------------------------------
  // Front end: take items only once the counters are cleared
  // --------------------------------------------------------------------------
  assign full = back_stat.clearing || !front_ready;

  mah_front #(
    .NUM_BINS (NUM_BINS),
    .BIN_W    (BIN_W)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg),
    .in_valid_i       (push && !back_stat.clearing),
    .in_ready_o       (front_ready),
    .kind_i           (kind_i),
    .access_address_i (access_address_i),
    .access_type_i    (access_type_i),
    .mid_push_o       (mid_push),
    .mid_item_o       (mid_item_w),
    .mid_bin_o        (mid_bin_w),
    .mid_full_i       (mid_full)
  );

  // Decoupling queue between classification and counter update
  mah_queue #(
    .WIDTH ($bits(item_t) + BIN_W),
    .DEPTH (2)
  ) u_mid_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (mid_push),
    .data_i  ({mid_item_w, mid_bin_w}),
    .full_o  (mid_full),
    .pop_i   (mid_pop),
    .data_o  (mid_rd_data),
    .empty_o (mid_empty)
  );

  assign {mid_item_r, mid_bin_r} = mid_rd_data;

  // --------------------------------------------------------------------------
  // Back end: counter memories and update sequencer
  // --------------------------------------------------------------------------
  mah_back #(
    .NUM_BINS   (NUM_BINS),
    .COUNT_BITS (COUNT_BITS),
    .BIN_W      (BIN_W)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mid_empty_i (mid_empty),
    .mid_item_i  (mid_item_r),
    .mid_bin_i   (mid_bin_r),
    .mid_pop_o   (mid_pop),
    .out_push_o  (out_push),
    .out_res_o   (back_res),
    .out_full_i  (out_full),
    .stat_o      (back_stat)
  );

  // Result queue: holds finished results while the consumer stalls
  mah_queue #(
    .WIDTH ($bits(res_t)),
    .DEPTH (2)
  ) u_out_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .data_i  (back_res),
    .full_o  (out_full),
    .pop_i   (pop),
    .data_o  (out_res),
    .empty_o (empty)
  );

  assign status_o       = out_res.status;
  assign type_warning_o = out_res.warn;
  assign first_count_o  = out_res.first_count;
  assign second_count_o = out_res.second_count;
  assign third_count_o  = out_res.third_count;
  assign total_count_o  = out_res.total_count;
  assign bar_length_o   = out_res.bar_length;

endmodule

### hdl/mah_queue.sv
// Small synchronous FIFO used between front and back and at the result side.
// Generic payload width; no package dependencies.
module mah_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = slots_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

### hdl/mah_front.sv
// Front end: register an accepted item and classify it into status, warning and bin.
// Depends on mah_pkg (cfg_t, item_t, codes).
module mah_front #(
  parameter int NUM_BINS = 1024,
  parameter int BIN_W    = 10
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mah_pkg::cfg_t      cfg_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               kind_i,
  input  logic [31:0]        access_address_i,
  input  logic [7:0]         access_type_i,
  output logic               mid_push_o,
  output mah_pkg::item_t     mid_item_o,
  output logic [BIN_W-1:0]   mid_bin_o,
  input  logic               mid_full_i
);
  import mah_pkg::*;

  logic        a_valid_q, a_valid_d;
  logic        a_kind_q;
  logic [31:0] a_addr_q;
  logic [7:0]  a_type_q;
  logic        a_load;

  logic [31:0] bin_addr, rel;
  logic        in_cap, out_win;
  logic [7:0]  type_eff, cls;
  logic [1:0]  warn, which;

  // Stage A holds while the queue is full
  assign in_ready_o = !a_valid_q || !mid_full_i;
  assign a_load     = in_valid_i && in_ready_o;
  assign mid_push_o = a_valid_q && !mid_full_i;

  always_comb begin
    a_valid_d = a_valid_q;
    if (a_load) begin
      a_valid_d = 1'b1;
    end else if (mid_push_o) begin
      a_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else begin
      a_valid_q <= a_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_load) begin
      a_kind_q <= kind_i;
      a_addr_q <= access_address_i;
      a_type_q <= access_type_i;
    end
  end

  // Classify the held item
  always_comb begin
    bin_addr = a_addr_q >> cfg_i.group_shift;
    rel      = bin_addr - cfg_i.start_bin;
    in_cap   = (rel < 32'(NUM_BINS));
    out_win  = (a_addr_q < cfg_i.window_start) || (a_addr_q > cfg_i.window_end);

    type_eff = a_type_q;
    warn     = WARN_NONE;
    if (a_type_q > TYPE_LIMIT) begin
      type_eff = '0;
      warn     = WARN_TYPE_RANGE;
    end
    cls = cfg_i.width_mode ? (type_eff >> WIDTH_SHIFT) : (type_eff & KIND_MASK);
    case (cls)
      CLS_FIRST:  which = CNT_FIRST;
      CLS_SECOND: which = CNT_SECOND;
      CLS_THIRD:  which = CNT_THIRD;
      default: begin
        which = CNT_FIRST;
        if (warn == WARN_NONE) begin
          warn = WARN_CLASS;
        end
      end
    endcase

    mid_item_o.which = which;
    if (a_kind_q == KIND_RECORD) begin
      if (out_win) begin
        mid_item_o.status = ST_OUT_WINDOW;
        mid_item_o.warn   = WARN_NONE;
      end else begin
        mid_item_o.status = in_cap ? ST_RECORDED : ST_NO_CAPACITY;
        mid_item_o.warn   = warn;
      end
    end else begin
      mid_item_o.warn = WARN_NONE;
      if ((bin_addr < cfg_i.start_bin) || (bin_addr > cfg_i.end_bin) || cfg_i.win_empty) begin
        mid_item_o.status = ST_OUT_WINDOW;
      end else if (!in_cap) begin
        mid_item_o.status = ST_NO_CAPACITY;
      end else begin
        mid_item_o.status = ST_QUERY_OK;
      end
    end
  end

  assign mid_bin_o = rel[BIN_W-1:0];

  // A stalled item stays put until the queue takes it
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_valid_q && mid_full_i) |=> (a_valid_q && $stable(a_addr_q) && $stable(a_kind_q)))
    else $error("front stage dropped a stalled item");

endmodule

### hdl/mah_back.sv
// Back end: counter memories, clearing pass and the read-modify-write sequencer.
// Depends on mah_pkg (item_t, res_t, back_state_e, codes).
module mah_back #(
  parameter int NUM_BINS   = 1024,
  parameter int COUNT_BITS = 32,
  parameter int BIN_W      = 10
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                mid_empty_i,
  input  mah_pkg::item_t      mid_item_i,
  input  logic [BIN_W-1:0]    mid_bin_i,
  output logic                mid_pop_o,
  output logic                out_push_o,
  output mah_pkg::res_t       out_res_o,
  input  logic                out_full_i,
  output mah_pkg::back_stat_t stat_o
);
  import mah_pkg::*;

  back_state_e state_q, state_d;
  logic [BIN_W-1:0] clr_cnt_q, clr_cnt_d;
  item_t            cur_q;
  logic [BIN_W-1:0] cur_bin_q;
  logic             load;

  logic [COUNT_BITS-1:0] mem0 [NUM_BINS];
  logic [COUNT_BITS-1:0] mem1 [NUM_BINS];
  logic [COUNT_BITS-1:0] mem2 [NUM_BINS];
  logic [COUNT_BITS-1:0] rd0_q, rd1_q, rd2_q;
  logic [COUNT_BITS-1:0] sel_cnt, wr_data;
  logic [BIN_W-1:0]      wr_addr;
  logic [2:0]            we;
  logic                  rd_en, total_en;

  logic [31:0] c0, c1, c2;
  logic [33:0] total_q;
  logic [33:0] lower;
  logic [6:0]  len, bar;
  logic        nxt, qok;

  assign c0 = 32'(rd0_q);
  assign c1 = 32'(rd1_q);
  assign c2 = 32'(rd2_q);

  always_comb begin
    case (cur_q.which)
      CNT_SECOND: sel_cnt = rd1_q;
      CNT_THIRD:  sel_cnt = rd2_q;
      default:    sel_cnt = rd0_q;
    endcase
  end

  always_comb begin
    state_d    = state_q;
    clr_cnt_d  = clr_cnt_q;
    mid_pop_o  = 1'b0;
    load       = 1'b0;
    we         = 3'b000;
    wr_addr    = cur_bin_q;
    wr_data    = (&sel_cnt) ? sel_cnt : sel_cnt + COUNT_BITS'(1);
    rd_en      = 1'b0;
    total_en   = 1'b0;
    out_push_o = 1'b0;
    case (state_q)
      BK_CLEAR: begin
        we      = 3'b111;
        wr_addr = clr_cnt_q;
        wr_data = '0;
        if (clr_cnt_q == BIN_W'(NUM_BINS - 1)) begin
          state_d = BK_IDLE;
        end else begin
          clr_cnt_d = clr_cnt_q + BIN_W'(1);
        end
      end
      BK_IDLE: begin
        if (!mid_empty_i) begin
          mid_pop_o = 1'b1;
          load      = 1'b1;
          if ((mid_item_i.status == ST_RECORDED) || (mid_item_i.status == ST_QUERY_OK)) begin
            state_d = BK_READ;
          end else begin
            state_d = BK_EMIT;
          end
        end
      end
      BK_READ: begin
        rd_en   = 1'b1;
        state_d = BK_UPDATE;
      end
      BK_UPDATE: begin
        total_en = 1'b1;
        if (cur_q.status == ST_RECORDED) begin
          case (cur_q.which)
            CNT_SECOND: we = 3'b010;
            CNT_THIRD:  we = 3'b100;
            default:    we = 3'b001;
          endcase
        end
        state_d = BK_EMIT;
      end
      BK_EMIT: begin
        if (!out_full_i) begin
          out_push_o = 1'b1;
          state_d    = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BK_CLEAR;
      clr_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cur_q     <= mid_item_i;
      cur_bin_q <= mid_bin_i;
    end
    if (total_en) begin
      total_q <= 34'(c0) + 34'(c1) + 34'(c2);
    end
  end

  // Counter memories: one write port, registered read
  always_ff @(posedge clk_i) begin
    if (we[0]) begin
      mem0[wr_addr] <= wr_data;
    end
    if (we[1]) begin
      mem1[wr_addr] <= wr_data;
    end
    if (we[2]) begin
      mem2[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd0_q <= mem0[cur_bin_q];
      rd1_q <= mem1[cur_bin_q];
      rd2_q <= mem2[cur_bin_q];
    end
  end

  // Bit length of the total and the bit just below its leading one
  always_comb begin
    lower = {total_q[32:0], 1'b0};
    len   = '0;
    nxt   = 1'b0;
    for (int i = 0; i < 34; i++) begin
      if (total_q[i]) begin
        len = 7'(i + 1);
        nxt = lower[i];
      end
    end
    bar = (len == '0) ? '0 : 7'((len << 1) - 7'd1 + 7'(nxt));
  end

  assign qok = (cur_q.status == ST_QUERY_OK);

  always_comb begin
    out_res_o.status       = cur_q.status;
    out_res_o.warn         = cur_q.warn;
    out_res_o.first_count  = qok ? c0 : '0;
    out_res_o.second_count = qok ? c1 : '0;
    out_res_o.third_count  = qok ? c2 : '0;
    out_res_o.total_count  = qok ? total_q : '0;
    out_res_o.bar_length   = qok ? bar : '0;
  end

  assign stat_o.clearing = (state_q == BK_CLEAR);

  // A record bumps exactly one counter
  we_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != BK_CLEAR) |-> $onehot0(we))
    else $error("more than one counter written for one record");

  // Only successful queries report counts
  zero_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_push_o && (out_res_o.status != ST_QUERY_OK)) |->
      ((out_res_o.total_count == '0) && (out_res_o.bar_length == '0)))
    else $error("counts reported on a non-query result");

  // The clearing pass ends after the last entry
  clear_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == BK_CLEAR) && (clr_cnt_q == BIN_W'(NUM_BINS - 1))) |=> (state_q == BK_IDLE))
    else $error("clearing pass did not finish");

endmodule
